[rtl/multi_slot_bounded_list_store_core_defines.svh]
// Assertion macros for the list store core.
// Used by multi_slot_bounded_list_store_core; expects clk and rst_n in scope.
`ifndef MULTI_SLOT_BOUNDED_LIST_STORE_CORE_DEFINES_SVH
`define MULTI_SLOT_BOUNDED_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MSLSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list store check failed");

// next-cycle implication, disabled in reset
`define MSLSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list store check failed");

`endif

[rtl/mslsc_pkg.sv]
// Types and codes of the list store core: item structs, operation and status codes.
// No dependencies.
package mslsc_pkg;

  localparam int FILL_W = 7;
  localparam int AMT_W  = 8;
  localparam int VAL_W  = 32;

  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_DROP   = 3'd2;
  localparam logic [2:0] OP_DELETE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_RESIZE = 3'd5;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_SLOT  = 4'd1;
  localparam logic [3:0] ST_BAD_SIZE  = 4'd2;
  localparam logic [3:0] ST_EXISTS    = 4'd3;
  localparam logic [3:0] ST_NO_MEM    = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_ABSENT    = 4'd6;
  localparam logic [3:0] ST_EMPTY     = 4'd7;
  localparam logic [3:0] ST_NOT_FOUND = 4'd8;
  localparam logic [3:0] ST_BAD_NEW   = 4'd9;

  typedef struct packed {
    logic [2:0]              operation;
    logic [3:0]              slot;
    logic signed [AMT_W-1:0] amount;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]              status;
    logic                    has_value;
    logic signed [VAL_W-1:0] element;
    logic [FILL_W-1:0]       fill;
    logic                    last;
  } out_item_t;

endpackage

[rtl/multi_slot_bounded_list_store_core.sv]
// List store core: numbered bounded lists over one element memory.
// Depends on mslsc_pkg and multi_slot_bounded_list_store_core_defines.svh.
//
//   channel  | signals                    | direction | holds
//   ---------+----------------------------+-----------+----------------------------
//   in       | in_valid/in_ready/in_item  | to core   | operation, slot, amount, value
//   out      | out_valid/out_ready/out_item | from core | status, element, fill, last
//
// Create, append, drop, resize, absent and error cases pass through S_CHECK and S_FINISH to one result.
// Read all: one element per cycle while out_ready holds for a non-empty list; an empty list gives one result.
// Delete: search, then shift later elements down through the single memory port pair.
// Reset (rst_n low, synchronous) clears list flags, capacities and fills; no memory sweep.
// A stalled out channel holds the current result and pauses the item in progress.
`include "multi_slot_bounded_list_store_core_defines.svh"

module multi_slot_bounded_list_store_core #(
  parameter int SLOTS   = 10,
  parameter int MAX_CAP = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mslsc_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mslsc_pkg::out_item_t out_item
);
  import mslsc_pkg::*;

  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = (MAX_CAP > 1) ? $clog2(MAX_CAP) : 1;
  localparam int DEPTH  = SLOTS * MAX_CAP;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NC_W   = FILL_W + 2;
  localparam logic [3:0]              SLOT_MAX = 4'(SLOTS);
  localparam logic [FILL_W-1:0]       CAP_MAX  = FILL_W'(MAX_CAP);
  localparam logic signed [NC_W-1:0]  CAP_LIM  = NC_W'(MAX_CAP);
  localparam logic signed [NC_W-1:0]  NC_ONE   = NC_W'(1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_SEARCH  = 6'b000100,
    S_SHIFT   = 6'b001000,
    S_RD_DATA = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          req_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [3:0]        status_r, status_nxt;

  logic              present_r [SLOTS];
  logic [FILL_W-1:0] cap_r     [SLOTS];
  logic [FILL_W-1:0] fill_r    [SLOTS];

  logic [VAL_W-1:0]  mem [DEPTH];
  logic [VAL_W-1:0]  rdata_r;

  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              slot_ok, cur_present;
  logic [SIDX_W-1:0] sidx;
  logic [FILL_W-1:0] cur_cap, cur_fill;
  logic [FILL_W-1:0] idx_p1, idx_p2;
  logic signed [NC_W-1:0] amt_ext, newcap;
  logic              out_free;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  wr_idx, rd_idx;
  logic [VAL_W-1:0]  wr_data;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic              meta_we, meta_present;
  logic [FILL_W-1:0] meta_cap, meta_fill;

  logic              emit;
  out_item_t         emit_item;

  assign slot_ok     = (req_r.slot != 4'd0) && (req_r.slot <= SLOT_MAX);
  assign sidx        = SIDX_W'(req_r.slot - 4'd1);
  assign cur_present = slot_ok && present_r[sidx];
  assign cur_cap     = cur_present ? cap_r[sidx] : '0;
  assign cur_fill    = cur_present ? fill_r[sidx] : '0;
  assign idx_p1      = FILL_W'(idx_r) + FILL_W'(1);
  assign idx_p2      = FILL_W'(idx_r) + FILL_W'(2);
  assign amt_ext     = {{(NC_W-AMT_W){req_r.amount[AMT_W-1]}}, req_r.amount};
  assign newcap      = signed'({2'b00, cur_cap}) + amt_ext;
  assign out_free    = !out_valid_r || out_ready;
  assign wr_addr     = ADDR_W'(int'(sidx) * MAX_CAP + int'(wr_idx));
  assign rd_addr     = ADDR_W'(int'(sidx) * MAX_CAP + int'(rd_idx));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    status_nxt   = status_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_idx       = idx_r;
    rd_idx       = idx_r;
    wr_data      = rdata_r;
    meta_we      = 1'b0;
    meta_present = cur_present;
    meta_cap     = cur_cap;
    meta_fill    = cur_fill;
    emit         = 1'b0;
    emit_item    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_FINISH;
        if (req_r.operation > OP_RESIZE) begin
          state_nxt = S_IDLE;
        end else if (!slot_ok) begin
          status_nxt = ST_BAD_SLOT;
        end else begin
          case (req_r.operation)
            OP_CREATE: begin
              if (req_r.amount < 8'sd1) begin
                status_nxt = ST_BAD_SIZE;
              end else if (cur_present) begin
                status_nxt = ST_EXISTS;
              end else if (amt_ext > CAP_LIM) begin
                status_nxt = ST_NO_MEM;
              end else begin
                status_nxt   = ST_OK;
                meta_we      = 1'b1;
                meta_present = 1'b1;
                meta_cap     = FILL_W'(req_r.amount);
                meta_fill    = '0;
              end
            end
            OP_APPEND: begin
              if (!cur_present) begin
                status_nxt = ST_ABSENT;
              end else if (cur_fill >= cur_cap || cur_fill >= CAP_MAX) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_OK;
                mem_we     = 1'b1;
                wr_idx     = IDX_W'(cur_fill);
                wr_data    = req_r.item_value;
                meta_we    = 1'b1;
                meta_fill  = cur_fill + FILL_W'(1);
              end
            end
            OP_DROP: begin
              if (!cur_present) begin
                status_nxt = ST_ABSENT;
              end else if (cur_fill == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                status_nxt = ST_OK;
                meta_we    = 1'b1;
                meta_fill  = cur_fill - FILL_W'(1);
              end
            end
            OP_DELETE: begin
              if (!cur_present) begin
                status_nxt = ST_ABSENT;
              end else if (cur_fill == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                rd_idx    = '0;
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            OP_READ: begin
              if (!cur_present) begin
                status_nxt = ST_ABSENT;
              end else begin
                status_nxt = ST_OK;
                if (cur_fill != '0) begin
                  mem_re    = 1'b1;
                  rd_idx    = '0;
                  idx_nxt   = '0;
                  state_nxt = S_RD_DATA;
                end
              end
            end
            OP_RESIZE: begin
              if (!cur_present) begin
                status_nxt = ST_ABSENT;
              end else if (newcap < NC_ONE) begin
                status_nxt = ST_BAD_NEW;
              end else if (newcap > CAP_LIM) begin
                status_nxt = ST_NO_MEM;
              end else begin
                status_nxt = ST_OK;
                meta_we    = 1'b1;
                meta_cap   = FILL_W'(newcap);
                meta_fill  = (cur_fill > FILL_W'(newcap)) ? FILL_W'(newcap) : cur_fill;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rdata_r == req_r.item_value) begin
          if (idx_p1 < cur_fill) begin
            mem_re    = 1'b1;
            rd_idx    = IDX_W'(idx_p1);
            state_nxt = S_SHIFT;
          end else begin
            meta_we    = 1'b1;
            meta_fill  = cur_fill - FILL_W'(1);
            status_nxt = ST_OK;
            state_nxt  = S_FINISH;
          end
        end else if (idx_p1 < cur_fill) begin
          mem_re  = 1'b1;
          rd_idx  = IDX_W'(idx_p1);
          idx_nxt = IDX_W'(idx_p1);
        end else begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FINISH;
        end
      end
      S_SHIFT: begin
        mem_we  = 1'b1;
        wr_idx  = idx_r;
        wr_data = rdata_r;
        idx_nxt = IDX_W'(idx_p1);
        if (idx_p2 < cur_fill) begin
          mem_re = 1'b1;
          rd_idx = IDX_W'(idx_p2);
        end else begin
          meta_we    = 1'b1;
          meta_fill  = cur_fill - FILL_W'(1);
          status_nxt = ST_OK;
          state_nxt  = S_FINISH;
        end
      end
      S_RD_DATA: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_item.status    = ST_OK;
          emit_item.has_value = 1'b1;
          emit_item.element   = rdata_r;
          emit_item.fill      = cur_fill;
          emit_item.last      = (idx_p1 == cur_fill);
          if (idx_p1 == cur_fill) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re  = 1'b1;
            rd_idx  = IDX_W'(idx_p1);
            idx_nxt = IDX_W'(idx_p1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_item.status = status_r;
          emit_item.fill   = cur_fill;
          emit_item.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        present_r[k] <= 1'b0;
        cap_r[k]     <= '0;
        fill_r[k]    <= '0;
      end
    end else if (meta_we) begin
      present_r[sidx] <= meta_present;
      cap_r[sidx]     <= meta_cap;
      fill_r[sidx]    <= meta_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= emit_item;
    end
  end

  `MSLSC_ASSERT_IMP(a_fill_in_cap, cur_present, cur_fill <= cur_cap)
  `MSLSC_ASSERT_IMP(a_cap_range, cur_present, (cur_cap != '0) && (cur_cap <= CAP_MAX))
  `MSLSC_ASSERT_IMP(a_read_in_fill, state_r == S_RD_DATA, idx_p1 <= cur_fill)
  `MSLSC_ASSERT_IMP(a_shift_in_fill, state_r == S_SHIFT, idx_p1 < cur_fill)
  `MSLSC_ASSERT_NXT(a_emit_shows, emit, out_valid_r)

endmodule

[sim/multi_slot_bounded_list_store_core_tb.sv]
// Testbench for multi_slot_bounded_list_store_core: directed and random list operations
// checked item by item against a scoreboard of predicted results.
// Depends on mslsc_pkg and the core RTL.
module multi_slot_bounded_list_store_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mslsc_pkg::*;

  localparam int SLOTS      = 10;
  localparam int MAX_CAP    = 32;
  localparam int STALL_MAX  = 3000;
  localparam int TAIL_WAIT  = 12;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  logic [VAL_W-1:0] list_mem [SLOTS][MAX_CAP];
  bit               list_on  [SLOTS];
  int               list_cap [SLOTS];
  int               list_cnt [SLOTS];

  out_item_t pending_list_results[$];
  logic [VAL_W-1:0] value_pool[8];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;

  multi_slot_bounded_list_store_core #(
    .SLOTS  (SLOTS),
    .MAX_CAP(MAX_CAP)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_single(input logic [3:0] status, input int fill);
    out_item_t r;
    r.status    = status;
    r.has_value = 1'b0;
    r.element   = '0;
    r.fill      = FILL_W'(fill);
    r.last      = 1'b1;
    pending_list_results.push_back(r);
  endtask

  task automatic apply_list_op(input in_item_t it);
    int s;
    int n;
    int i;
    int amt;
    int newcap;
    out_item_t r;
    if (it.operation == OP_UNUSED_LO || it.operation == OP_UNUSED_HI) return;
    if (it.slot < 1 || it.slot > SLOTS) begin
      push_single(ST_BAD_SLOT, 0);
      return;
    end
    s   = it.slot - 1;
    amt = $signed(it.amount);
    case (it.operation)
      OP_CREATE: begin
        if (amt < 1) push_single(ST_BAD_SIZE, list_on[s] ? list_cnt[s] : 0);
        else if (list_on[s]) push_single(ST_EXISTS, list_cnt[s]);
        else if (amt > MAX_CAP) push_single(ST_NO_MEM, 0);
        else begin
          list_on[s]  = 1'b1;
          list_cap[s] = amt;
          list_cnt[s] = 0;
          push_single(ST_OK, 0);
        end
      end
      OP_APPEND: begin
        if (!list_on[s]) push_single(ST_ABSENT, 0);
        else if (list_cnt[s] >= list_cap[s] || list_cnt[s] >= MAX_CAP)
          push_single(ST_FULL, list_cnt[s]);
        else begin
          list_mem[s][list_cnt[s]] = it.item_value;
          list_cnt[s]++;
          push_single(ST_OK, list_cnt[s]);
        end
      end
      OP_DROP: begin
        if (!list_on[s]) push_single(ST_ABSENT, 0);
        else if (list_cnt[s] == 0) push_single(ST_EMPTY, 0);
        else begin
          list_cnt[s]--;
          push_single(ST_OK, list_cnt[s]);
        end
      end
      OP_DELETE: begin
        n = list_cnt[s];
        if (!list_on[s]) push_single(ST_ABSENT, 0);
        else if (n == 0) push_single(ST_EMPTY, 0);
        else begin
          for (i = 0; i < n; i++)
            if (list_mem[s][i] == it.item_value) break;
          if (i >= n) push_single(ST_NOT_FOUND, n);
          else begin
            for (; i + 1 < n; i++) list_mem[s][i] = list_mem[s][i+1];
            list_cnt[s] = n - 1;
            push_single(ST_OK, list_cnt[s]);
          end
        end
      end
      OP_READ: begin
        n = list_cnt[s];
        if (!list_on[s]) push_single(ST_ABSENT, 0);
        else if (n == 0) push_single(ST_OK, 0);
        else begin
          for (i = 0; i < n; i++) begin
            r.status    = ST_OK;
            r.has_value = 1'b1;
            r.element   = list_mem[s][i];
            r.fill      = FILL_W'(n);
            r.last      = (i == n - 1);
            pending_list_results.push_back(r);
          end
        end
      end
      OP_RESIZE: begin
        newcap = list_cap[s] + amt;
        if (!list_on[s]) push_single(ST_ABSENT, 0);
        else if (newcap < 1) push_single(ST_BAD_NEW, list_cnt[s]);
        else if (newcap > MAX_CAP) push_single(ST_NO_MEM, list_cnt[s]);
        else begin
          list_cap[s] = newcap;
          if (list_cnt[s] > newcap) list_cnt[s] = newcap;
          push_single(ST_OK, list_cnt[s]);
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [2:0] op, input int slot, input int amt,
                                         input logic [VAL_W-1:0] value);
    in_item_t it;
    it.operation  = op;
    it.slot       = 4'(slot);
    it.amount     = AMT_W'(amt);
    it.item_value = value;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_op(it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_list_results.size() == 0) begin
        $error("unexpected result: status %0d element %h", out_item.status, out_item.element);
        fail_count++;
      end else begin
        want = pending_list_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.has_value !== want.has_value) begin
          $error("has_value: expected %0d, got %0d", want.has_value, out_item.has_value);
          fail_count++;
        end
        if (out_item.element !== want.element) begin
          $error("element: expected %h, got %h", want.element, out_item.element);
          fail_count++;
        end
        if (out_item.fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, out_item.fill);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic test_slot_and_create();
    send_item(make_item(OP_READ, 0, 0, 32'h0));
    send_item(make_item(OP_APPEND, 15, 0, 32'hffff_ffff));
    send_item(make_item(OP_CREATE, SLOTS + 1, 5, 32'h0));
    send_item(make_item(OP_CREATE, 1, 0, 32'h0));
    send_item(make_item(OP_CREATE, 1, -128, 32'h0));
    send_item(make_item(OP_CREATE, 1, MAX_CAP + 1, 32'h0));
    send_item(make_item(OP_CREATE, 1, 127, 32'h0));
    send_item(make_item(OP_CREATE, 1, 1, 32'h0));
    send_item(make_item(OP_CREATE, 1, 4, 32'h0));
    send_item(make_item(OP_DROP, 2, 0, 32'h0));
  endtask

  task automatic test_list_ops();
    send_item(make_item(OP_APPEND, 1, 0, 32'h8000_0000));
    send_item(make_item(OP_APPEND, 1, 0, 32'h7fff_ffff));
    send_item(make_item(OP_READ, 1, 0, 32'h0));
    send_item(make_item(OP_DELETE, 1, 0, 32'h5));
    send_item(make_item(OP_DELETE, 1, 0, 32'h8000_0000));
    send_item(make_item(OP_DELETE, 1, 0, 32'h8000_0000));
    send_item(make_item(OP_DROP, 1, 0, 32'h0));
    send_item(make_item(OP_READ, 1, 0, 32'h0));
  endtask

  task automatic test_resize_clip();
    send_item(make_item(OP_CREATE, SLOTS, MAX_CAP, 32'h0));
    send_item(make_item(OP_RESIZE, SLOTS, 1, 32'h0));
    send_item(make_item(OP_RESIZE, SLOTS, -MAX_CAP, 32'h0));
    for (int i = 0; i < 3; i++) send_item(make_item(OP_APPEND, SLOTS, 0, 32'(21 + i)));
    send_item(make_item(OP_RESIZE, SLOTS, 2 - MAX_CAP, 32'h0));
    send_item(make_item(OP_READ, SLOTS, 0, 32'h0));
    send_item(make_item(OP_RESIZE, 3, 4, 32'h0));
  endtask

  task automatic test_unknown_ops();
    send_item(make_item(OP_UNUSED_LO, 1, -1, 32'hffff_ffff));
    send_item(make_item(OP_UNUSED_HI, 15, 127, 32'h0));
  endtask

  task automatic run_random(input int count, input int drain_every);
    in_item_t it;
    int done;
    int r;
    int s;
    done = 0;
    while (done < count) begin
      it.slot = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, SLOTS));
      it.amount     = AMT_W'($urandom_range(255));
      it.item_value = ($urandom_range(1) == 0) ? VAL_W'($urandom()) : value_pool[$urandom_range(7)];
      r = $urandom_range(99);
      if (r < 8) begin
        it.operation = OP_CREATE;
        if ($urandom_range(99) < 85) it.amount = AMT_W'($urandom_range(1, MAX_CAP));
      end else if (r < 40) it.operation = OP_APPEND;
      else if (r < 52) it.operation = OP_DROP;
      else if (r < 68) begin
        it.operation = OP_DELETE;
        s = it.slot - 1;
        if (it.slot >= 1 && it.slot <= SLOTS && list_cnt[s] > 0 && $urandom_range(99) < 60)
          it.item_value = list_mem[s][$urandom_range(list_cnt[s] - 1)];
      end else if (r < 82) it.operation = OP_READ;
      else if (r < 96) begin
        it.operation = OP_RESIZE;
        if ($urandom_range(99) < 80) it.amount = AMT_W'(int'($urandom_range(16)) - 8);
      end else it.operation = ($urandom_range(1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
      send_item(it);
      if (it.operation != OP_UNUSED_LO && it.operation != OP_UNUSED_HI) begin
        done++;
        if (drain_every > 0 && done % drain_every == 0) drain_results();
      end
    end
  endtask

  task automatic test_random_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(110, 0);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_random(105, 0);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_random(110, 25);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    run_random(110, 0);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      list_on[i]  = 1'b0;
      list_cap[i] = 0;
      list_cnt[i] = 0;
    end
    foreach (value_pool[i]) value_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_slot_and_create();
    test_list_ops();
    test_resize_clip();
    test_unknown_ops();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();

    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[multi_slot_bounded_list_store_core.f]
+incdir+rtl
rtl/mslsc_pkg.sv
rtl/multi_slot_bounded_list_store_core.sv
sim/multi_slot_bounded_list_store_core_tb.sv
